// ===== rtl/pthc_pkg.sv =====
// ----------------------------------------------------------------------------
// pthc_pkg
// Shared constants, register indexes and the divider step for the
// pressure/temperature/humidity compensation pipeline.
// ----------------------------------------------------------------------------
package pthc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_P9    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB   = 3'd4;

    // Pipeline shape
    localparam int FRONT_STAGES = 13;
    localparam int DIV_STAGES   = 64;
    localparam int POST_STAGES  = 5;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + POST_STAGES;

    // Formula constants
    localparam logic signed [32:0] PRESS_T_OFFSET = 33'sd128000;
    localparam logic [31:0] HUM_T_OFFSET  = 32'd76800;
    localparam logic [20:0] PRESS_BASE    = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE   = 12'd3125;
    localparam logic [31:0] HUM_ROUND_X   = 32'd16384;
    localparam logic [31:0] HUM_OFS_Y1    = 32'd32768;
    localparam logic [31:0] HUM_OFS_Y2    = 32'd2097152;
    localparam logic [31:0] HUM_ROUND_Y   = 32'd8192;
    localparam logic [31:0] HUM_CLAMP     = 32'd419430400;
    localparam logic [63:0] PRESS_V1_OFS  = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] aq;
    } div_step_t;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic div_step_t div_step(input logic [63:0] rem,
                                           input logic [63:0] aq,
                                           input logic [63:0] dvs);
        logic [64:0] trial;
        logic [64:0] diff;
        div_step_t   r;
        trial = {rem, aq[63]};
        diff  = trial - {1'b0, dvs};
        if (!diff[64]) begin
            r.rem = diff[63:0];
            r.aq  = {aq[62:0], 1'b1};
        end else begin
            r.rem = trial[63:0];
            r.aq  = {aq[62:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/pth_sensor_compensation_unit.sv =====
// Samples pass the front, divider and post register stages in turn.
// Throughput: one sample per cycle while no result is held; the 64-stage
// restoring pressure divider is fully unrolled and sets the latency.
// A stall on the result side freezes every stage; nothing is dropped.
// Reset (aresetn, synchronous) clears all valid bits and the trim registers.
// ----------------------------------------------------------------------------
// pth_sensor_compensation_unit
// Integer compensation of raw pressure, temperature and humidity samples
// with trim coefficients from a configuration write port.
// ----------------------------------------------------------------------------
module pth_sensor_compensation_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pthc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [63:0]                     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [19:0]                     s_raw_pressure,
    input  logic [19:0]                     s_raw_temperature,
    input  logic [15:0]                     s_raw_humidity,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_temperature_centi,
    output logic signed [31:0]              m_fine_temperature,
    output logic [31:0]                     m_pressure_q24_8,
    output logic                            m_pressure_div_zero,
    output logic [16:0]                     m_humidity_q22_10
);
    import pthc_pkg::*;

    // Trim registers
    logic [47:0] temp_calib_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_p9_reg;
    logic [63:0] hum_calib_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_p9_reg   <= '0;
            hum_calib_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TEMP_CALIB: temp_calib_reg <= cfg_wdata[47:0];
                REG_PRESS_LOW:  press_lo_reg   <= cfg_wdata;
                REG_PRESS_HIGH: press_hi_reg   <= cfg_wdata;
                REG_PRESS_P9:   press_p9_reg   <= cfg_wdata[15:0];
                REG_HUM_CALIB:  hum_calib_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    logic        [15:0] t1;
    logic signed [15:0] t2, t3;
    logic        [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic        [7:0]  h1, h3;
    logic signed [15:0] h2;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = temp_calib_reg[15:0];
    assign t2 = $signed(temp_calib_reg[31:16]);
    assign t3 = $signed(temp_calib_reg[47:32]);
    assign p1 = press_lo_reg[15:0];
    assign p2 = $signed(press_lo_reg[31:16]);
    assign p3 = $signed(press_lo_reg[47:32]);
    assign p4 = $signed(press_lo_reg[63:48]);
    assign p5 = $signed(press_hi_reg[15:0]);
    assign p6 = $signed(press_hi_reg[31:16]);
    assign p7 = $signed(press_hi_reg[47:32]);
    assign p8 = $signed(press_hi_reg[63:48]);
    assign p9 = $signed(press_p9_reg);
    assign h1 = hum_calib_reg[7:0];
    assign h2 = $signed(hum_calib_reg[23:8]);
    assign h3 = hum_calib_reg[31:24];
    assign h4 = $signed(hum_calib_reg[43:32]);
    assign h5 = $signed(hum_calib_reg[55:44]);
    assign h6 = $signed(hum_calib_reg[63:56]);

    // Global advance: the whole pipe moves unless the result is held
    logic                   adv;
    logic [PIPE_STAGES-1:0] vld_reg;

    assign adv     = !vld_reg[PIPE_STAGES-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], s_valid};
        end
    end

    // ---------------- front stages ----------------
    // stage 1: temperature products
    logic signed [18:0] tdiff;
    logic signed [34:0] ta_prod;
    logic signed [17:0] tdlt;
    logic signed [35:0] dd_prod;
    logic [31:0] s1_ta_reg, s1_dd_reg;
    logic [19:0] s1_rp_reg;
    logic [15:0] s1_rh_reg;

    assign tdiff   = $signed({2'b0, s_raw_temperature[19:3]}) - $signed({2'b0, t1, 1'b0});
    assign ta_prod = tdiff * t2;
    assign tdlt    = $signed({2'b0, s_raw_temperature[19:4]}) - $signed({2'b0, t1});
    assign dd_prod = tdlt * tdlt;

    // stage 2
    logic signed [31:0] dd_sh;
    logic signed [47:0] tb_prod;
    logic [31:0] s2_a_reg, s2_tb_reg;
    logic [19:0] s2_rp_reg;
    logic [15:0] s2_rh_reg;

    assign dd_sh   = $signed(s1_dd_reg) >>> 12;
    assign tb_prod = dd_sh * t3;

    // stage 3: fine temperature
    logic [31:0] fine_next;
    logic [31:0] s3_fine_reg;
    logic [19:0] s3_rp_reg;
    logic [15:0] s3_rh_reg;

    assign fine_next = s2_a_reg + 32'($signed(s2_tb_reg) >>> 14);

    // stage 4: temperature result, offsets for pressure and humidity
    logic [31:0] temp5;
    logic [31:0] s4_temp_reg, s4_fine_reg, s4_hv_reg;
    logic signed [32:0] s4_v1_reg;
    logic [19:0] s4_rp_reg;
    logic [15:0] s4_rh_reg;

    assign temp5 = {s3_fine_reg[29:0], 2'b0} + s3_fine_reg + 32'd128;

    // stage 5
    logic signed [65:0] vv_prod;
    logic signed [48:0] v1p5_prod, v1p2_prod;
    logic signed [43:0] h5v_prod;
    logic signed [39:0] vh6_prod;
    logic signed [40:0] vh3_prod;
    logic [63:0] s5_vv_reg, s5_v1p5_reg, s5_v1p2_reg;
    logic [31:0] s5_h5v_reg, s5_vh6_reg, s5_vh3_reg;
    logic [31:0] s5_temp_reg, s5_fine_reg;
    logic [19:0] s5_rp_reg;
    logic [15:0] s5_rh_reg;

    assign vv_prod   = s4_v1_reg * s4_v1_reg;
    assign v1p5_prod = s4_v1_reg * p5;
    assign v1p2_prod = s4_v1_reg * p2;
    assign h5v_prod  = $signed(s4_hv_reg) * h5;
    assign vh6_prod  = $signed(s4_hv_reg) * h6;
    assign vh3_prod  = $signed(s4_hv_reg) * $signed({1'b0, h3});

    // stage 6
    logic signed [79:0] v2a_prod, v1a_prod;
    logic [31:0] hx_sum;
    logic [63:0] s6_v2a_reg, s6_v1a_reg, s6_v1p5_reg, s6_v1p2_reg;
    logic [31:0] s6_x_reg, s6_ya_reg, s6_yb_reg;
    logic [31:0] s6_temp_reg, s6_fine_reg;
    logic [19:0] s6_rp_reg;

    assign v2a_prod = $signed(s5_vv_reg) * p6;
    assign v1a_prod = $signed(s5_vv_reg) * p3;
    assign hx_sum   = {2'b0, s5_rh_reg, 14'b0} - {h4, 20'b0} - s5_h5v_reg + HUM_ROUND_X;

    // stage 7
    logic [63:0] p4_x;
    logic signed [63:0] y_prod;
    logic [63:0] s7_v2_reg, s7_v1b_reg;
    logic [31:0] s7_x_reg, s7_y_reg;
    logic [31:0] s7_temp_reg, s7_fine_reg;
    logic [19:0] s7_rp_reg;

    assign p4_x   = {{48{p4[15]}}, p4};
    assign y_prod = $signed(s6_ya_reg) * $signed(s6_yb_reg);

    // stage 8
    logic [20:0] pbase;
    logic [63:0] v1_sum;
    logic [79:0] v1x_prod;
    logic signed [31:0] y_sh;
    logic signed [47:0] yh_prod;
    logic [63:0] s8_pnum_reg, s8_v1x_reg;
    logic [31:0] s8_x_reg, s8_yh_reg;
    logic [31:0] s8_temp_reg, s8_fine_reg;

    assign pbase    = PRESS_BASE - {1'b0, s7_rp_reg};
    assign v1_sum   = PRESS_V1_OFS + s7_v1b_reg;
    assign v1x_prod = v1_sum * p1;
    assign y_sh     = ($signed(s7_y_reg) >>> 10) + $signed(HUM_OFS_Y2);
    assign yh_prod  = y_sh * h2;

    // stage 9
    logic [75:0] num_prod;
    logic [63:0] s9_num_reg, s9_v1c_reg;
    logic [31:0] s9_x_reg, s9_yf_reg;
    logic [31:0] s9_temp_reg, s9_fine_reg;

    assign num_prod = s8_pnum_reg * PRESS_SCALE;

    // stage 10: divider operand prep, humidity product
    logic signed [63:0] hv2_prod;
    logic [63:0] s10_ma_reg, s10_mb_reg;
    logic s10_neg_reg, s10_dz_reg;
    logic [31:0] s10_hv2_reg;
    logic [31:0] s10_temp_reg, s10_fine_reg;

    assign hv2_prod = $signed(s9_x_reg) * $signed(s9_yf_reg);

    // stage 11
    logic signed [31:0] hq;
    logic signed [63:0] qsq_prod;
    logic [63:0] s11_ma_reg, s11_mb_reg;
    logic s11_neg_reg, s11_dz_reg;
    logic [31:0] s11_hv2_reg, s11_qsq_reg;
    logic [31:0] s11_temp_reg, s11_fine_reg;

    assign hq       = $signed(s10_hv2_reg) >>> 15;
    assign qsq_prod = hq * hq;

    // stage 12
    logic signed [40:0] tq_prod;
    logic [63:0] s12_ma_reg, s12_mb_reg;
    logic s12_neg_reg, s12_dz_reg;
    logic [31:0] s12_hv2_reg, s12_tq_reg;
    logic [31:0] s12_temp_reg, s12_fine_reg;

    assign tq_prod = ($signed(s11_qsq_reg) >>> 7) * $signed({1'b0, h1});

    // stage 13: humidity clamp
    logic [31:0] hv3;
    logic [31:0] hclamp;
    logic [63:0] s13_ma_reg, s13_mb_reg;
    logic s13_neg_reg, s13_dz_reg;
    logic [16:0] s13_hum_reg;
    logic [31:0] s13_temp_reg, s13_fine_reg;

    assign hv3 = s12_hv2_reg - 32'($signed(s12_tq_reg) >>> 4);

    always_comb begin
        priority if (hv3[31]) begin
            hclamp = '0;
        end else if (hv3 > HUM_CLAMP) begin
            hclamp = HUM_CLAMP;
        end else begin
            hclamp = hv3;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            s1_ta_reg <= ta_prod[31:0];
            s1_dd_reg <= dd_prod[31:0];
            s1_rp_reg <= s_raw_pressure;
            s1_rh_reg <= s_raw_humidity;
            // stage 2
            s2_a_reg  <= 32'($signed(s1_ta_reg) >>> 11);
            s2_tb_reg <= tb_prod[31:0];
            s2_rp_reg <= s1_rp_reg;
            s2_rh_reg <= s1_rh_reg;
            // stage 3
            s3_fine_reg <= fine_next;
            s3_rp_reg   <= s2_rp_reg;
            s3_rh_reg   <= s2_rh_reg;
            // stage 4
            s4_temp_reg <= 32'($signed(temp5) >>> 8);
            s4_fine_reg <= s3_fine_reg;
            s4_v1_reg   <= $signed({s3_fine_reg[31], s3_fine_reg}) - PRESS_T_OFFSET;
            s4_hv_reg   <= s3_fine_reg - HUM_T_OFFSET;
            s4_rp_reg   <= s3_rp_reg;
            s4_rh_reg   <= s3_rh_reg;
            // stage 5
            s5_vv_reg   <= vv_prod[63:0];
            s5_v1p5_reg <= {{15{v1p5_prod[48]}}, v1p5_prod};
            s5_v1p2_reg <= {{15{v1p2_prod[48]}}, v1p2_prod};
            s5_h5v_reg  <= h5v_prod[31:0];
            s5_vh6_reg  <= vh6_prod[31:0];
            s5_vh3_reg  <= vh3_prod[31:0];
            s5_temp_reg <= s4_temp_reg;
            s5_fine_reg <= s4_fine_reg;
            s5_rp_reg   <= s4_rp_reg;
            s5_rh_reg   <= s4_rh_reg;
            // stage 6
            s6_v2a_reg  <= v2a_prod[63:0];
            s6_v1a_reg  <= v1a_prod[63:0];
            s6_v1p5_reg <= s5_v1p5_reg;
            s6_v1p2_reg <= s5_v1p2_reg;
            s6_x_reg    <= 32'($signed(hx_sum) >>> 15);
            s6_ya_reg   <= 32'($signed(s5_vh6_reg) >>> 10);
            s6_yb_reg   <= 32'($signed(s5_vh3_reg) >>> 11) + HUM_OFS_Y1;
            s6_temp_reg <= s5_temp_reg;
            s6_fine_reg <= s5_fine_reg;
            s6_rp_reg   <= s5_rp_reg;
            // stage 7
            s7_v2_reg   <= s6_v2a_reg + (s6_v1p5_reg << 17) + (p4_x << 35);
            s7_v1b_reg  <= 64'($signed(s6_v1a_reg) >>> 8) + (s6_v1p2_reg << 12);
            s7_x_reg    <= s6_x_reg;
            s7_y_reg    <= y_prod[31:0];
            s7_temp_reg <= s6_temp_reg;
            s7_fine_reg <= s6_fine_reg;
            s7_rp_reg   <= s6_rp_reg;
            // stage 8
            s8_pnum_reg <= {12'b0, pbase, 31'b0} - s7_v2_reg;
            s8_v1x_reg  <= v1x_prod[63:0];
            s8_x_reg    <= s7_x_reg;
            s8_yh_reg   <= yh_prod[31:0];
            s8_temp_reg <= s7_temp_reg;
            s8_fine_reg <= s7_fine_reg;
            // stage 9
            s9_num_reg  <= num_prod[63:0];
            s9_v1c_reg  <= 64'($signed(s8_v1x_reg) >>> 33);
            s9_x_reg    <= s8_x_reg;
            s9_yf_reg   <= 32'($signed(s8_yh_reg + HUM_ROUND_Y) >>> 14);
            s9_temp_reg <= s8_temp_reg;
            s9_fine_reg <= s8_fine_reg;
            // stage 10: magnitudes and sign of the quotient
            s10_ma_reg   <= s9_num_reg[63] ? (64'd0 - s9_num_reg) : s9_num_reg;
            s10_mb_reg   <= s9_v1c_reg[63] ? (64'd0 - s9_v1c_reg) : s9_v1c_reg;
            s10_neg_reg  <= s9_num_reg[63] ^ s9_v1c_reg[63];
            s10_dz_reg   <= (s9_v1c_reg == 64'd0);
            s10_hv2_reg  <= hv2_prod[31:0];
            s10_temp_reg <= s9_temp_reg;
            s10_fine_reg <= s9_fine_reg;
            // stage 11
            s11_ma_reg   <= s10_ma_reg;
            s11_mb_reg   <= s10_mb_reg;
            s11_neg_reg  <= s10_neg_reg;
            s11_dz_reg   <= s10_dz_reg;
            s11_hv2_reg  <= s10_hv2_reg;
            s11_qsq_reg  <= qsq_prod[31:0];
            s11_temp_reg <= s10_temp_reg;
            s11_fine_reg <= s10_fine_reg;
            // stage 12
            s12_ma_reg   <= s11_ma_reg;
            s12_mb_reg   <= s11_mb_reg;
            s12_neg_reg  <= s11_neg_reg;
            s12_dz_reg   <= s11_dz_reg;
            s12_hv2_reg  <= s11_hv2_reg;
            s12_tq_reg   <= tq_prod[31:0];
            s12_temp_reg <= s11_temp_reg;
            s12_fine_reg <= s11_fine_reg;
            // stage 13
            s13_ma_reg   <= s12_ma_reg;
            s13_mb_reg   <= s12_mb_reg;
            s13_neg_reg  <= s12_neg_reg;
            s13_dz_reg   <= s12_dz_reg;
            s13_hum_reg  <= hclamp[28:12];
            s13_temp_reg <= s12_temp_reg;
            s13_fine_reg <= s12_fine_reg;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    logic [63:0] dv_rem_reg  [DIV_STAGES];
    logic [63:0] dv_aq_reg   [DIV_STAGES];
    logic [63:0] dv_mb_reg   [DIV_STAGES];
    logic        dv_neg_reg  [DIV_STAGES];
    logic        dv_dz_reg   [DIV_STAGES];
    logic [16:0] dv_hum_reg  [DIV_STAGES];
    logic [31:0] dv_temp_reg [DIV_STAGES];
    logic [31:0] dv_fine_reg [DIV_STAGES];
    div_step_t   dv_step     [DIV_STAGES];

    always_comb begin
        dv_step[0] = div_step(64'd0, s13_ma_reg, s13_mb_reg);
        for (int k = 1; k < DIV_STAGES; k++) begin
            dv_step[k] = div_step(dv_rem_reg[k-1], dv_aq_reg[k-1], dv_mb_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0]  <= dv_step[0].rem;
            dv_aq_reg[0]   <= dv_step[0].aq;
            dv_mb_reg[0]   <= s13_mb_reg;
            dv_neg_reg[0]  <= s13_neg_reg;
            dv_dz_reg[0]   <= s13_dz_reg;
            dv_hum_reg[0]  <= s13_hum_reg;
            dv_temp_reg[0] <= s13_temp_reg;
            dv_fine_reg[0] <= s13_fine_reg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                dv_rem_reg[k]  <= dv_step[k].rem;
                dv_aq_reg[k]   <= dv_step[k].aq;
                dv_mb_reg[k]   <= dv_mb_reg[k-1];
                dv_neg_reg[k]  <= dv_neg_reg[k-1];
                dv_dz_reg[k]   <= dv_dz_reg[k-1];
                dv_hum_reg[k]  <= dv_hum_reg[k-1];
                dv_temp_reg[k] <= dv_temp_reg[k-1];
                dv_fine_reg[k] <= dv_fine_reg[k-1];
            end
        end
    end

    // ---------------- post stages: pressure correction ----------------
    logic [63:0] pa_p_reg;
    logic        pa_dz_reg;
    logic [16:0] pa_hum_reg;
    logic [31:0] pa_temp_reg, pa_fine_reg;

    logic signed [63:0] pb_ps;
    logic signed [79:0] m1_prod, w2p_prod;
    logic [63:0] pb_p_reg, pb_ps_reg, pb_m1_reg, pb_w2p_reg;
    logic        pb_dz_reg;
    logic [16:0] pb_hum_reg;
    logic [31:0] pb_temp_reg, pb_fine_reg;

    logic [63:0] ll_prod, lh_prod, hl_prod;
    logic [63:0] pc_p_reg, pc_ll_reg, pc_w2p_reg;
    logic [31:0] pc_lh_reg, pc_hl_reg;
    logic        pc_dz_reg;
    logic [16:0] pc_hum_reg;
    logic [31:0] pc_temp_reg, pc_fine_reg;

    logic [63:0] w1_full;
    logic [63:0] pd_p_reg, pd_w1_reg, pd_w2_reg;
    logic        pd_dz_reg;
    logic [16:0] pd_hum_reg;
    logic [31:0] pd_temp_reg, pd_fine_reg;

    logic [63:0] p7_x;
    logic [63:0] press_sum;
    logic [63:0] press_full;
    logic [31:0] out_press_reg;
    logic        out_dz_reg;
    logic [16:0] out_hum_reg;
    logic [31:0] out_temp_reg, out_fine_reg;

    assign pb_ps    = $signed(pa_p_reg) >>> 13;
    assign m1_prod  = pb_ps * p9;
    assign w2p_prod = $signed(pa_p_reg) * p8;
    assign ll_prod  = pb_m1_reg[31:0] * pb_ps_reg[31:0];
    assign lh_prod  = pb_m1_reg[31:0] * pb_ps_reg[63:32];
    assign hl_prod  = pb_m1_reg[63:32] * pb_ps_reg[31:0];
    assign w1_full  = pc_ll_reg + {pc_lh_reg + pc_hl_reg, 32'b0};
    assign p7_x     = {{48{p7[15]}}, p7};
    assign press_sum  = pd_p_reg + pd_w1_reg + pd_w2_reg;
    assign press_full = 64'($signed(press_sum) >>> 8) + (p7_x << 4);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // restore quotient sign
            pa_p_reg    <= dv_neg_reg[DIV_STAGES-1] ? (64'd0 - dv_aq_reg[DIV_STAGES-1])
                                                    : dv_aq_reg[DIV_STAGES-1];
            pa_dz_reg   <= dv_dz_reg[DIV_STAGES-1];
            pa_hum_reg  <= dv_hum_reg[DIV_STAGES-1];
            pa_temp_reg <= dv_temp_reg[DIV_STAGES-1];
            pa_fine_reg <= dv_fine_reg[DIV_STAGES-1];
            // first products of the correction terms
            pb_p_reg    <= pa_p_reg;
            pb_ps_reg   <= pb_ps;
            pb_m1_reg   <= m1_prod[63:0];
            pb_w2p_reg  <= w2p_prod[63:0];
            pb_dz_reg   <= pa_dz_reg;
            pb_hum_reg  <= pa_hum_reg;
            pb_temp_reg <= pa_temp_reg;
            pb_fine_reg <= pa_fine_reg;
            // partial products of the 64-bit square term
            pc_p_reg    <= pb_p_reg;
            pc_ll_reg   <= ll_prod;
            pc_lh_reg   <= lh_prod[31:0];
            pc_hl_reg   <= hl_prod[31:0];
            pc_w2p_reg  <= pb_w2p_reg;
            pc_dz_reg   <= pb_dz_reg;
            pc_hum_reg  <= pb_hum_reg;
            pc_temp_reg <= pb_temp_reg;
            pc_fine_reg <= pb_fine_reg;
            // combine partials, scale both terms
            pd_p_reg    <= pc_p_reg;
            pd_w1_reg   <= 64'($signed(w1_full) >>> 25);
            pd_w2_reg   <= 64'($signed(pc_w2p_reg) >>> 19);
            pd_dz_reg   <= pc_dz_reg;
            pd_hum_reg  <= pc_hum_reg;
            pd_temp_reg <= pc_temp_reg;
            pd_fine_reg <= pc_fine_reg;
            // output register; zero divisor forces pressure to zero
            out_press_reg <= pd_dz_reg ? 32'd0 : press_full[31:0];
            out_dz_reg    <= pd_dz_reg;
            out_hum_reg   <= pd_hum_reg;
            out_temp_reg  <= pd_temp_reg;
            out_fine_reg  <= pd_fine_reg;
        end
    end

    assign m_temperature_centi = $signed(out_temp_reg);
    assign m_fine_temperature  = $signed(out_fine_reg);
    assign m_pressure_q24_8    = out_press_reg;
    assign m_pressure_div_zero = out_dz_reg;
    assign m_humidity_q22_10   = out_hum_reg;

endmodule

// ===== tb/pthc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthc_checker
// Mirrors the trim registers from the configuration port, computes the
// compensated reading for every sample transfer and compares each result
// transfer, field by field, with the oldest outstanding reading.
// ----------------------------------------------------------------------------
module pthc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pthc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [63:0]                     cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [19:0]                     s_raw_pressure,
    input  logic [19:0]                     s_raw_temperature,
    input  logic [15:0]                     s_raw_humidity,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic signed [31:0]              m_temperature_centi,
    input  logic signed [31:0]              m_fine_temperature,
    input  logic [31:0]                     m_pressure_q24_8,
    input  logic                            m_pressure_div_zero,
    input  logic [16:0]                     m_humidity_q22_10,
    output int                              error_count,
    output int                              readings_pending
);
    import pthc_pkg::*;

    typedef struct {
        logic [31:0] temp_centi;
        logic [31:0] fine_temp;
        logic [31:0] pressure;
        logic        div_zero;
        logic [16:0] humidity;
    } reading_t;

    logic [47:0] trim_temp;
    logic [63:0] trim_press_lo;
    logic [63:0] trim_press_hi;
    logic [15:0] trim_p9;
    logic [63:0] trim_hum;
    reading_t    expected_readings[$];

    function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    // Truncating signed divide; most negative by -1 wraps to itself
    function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic reading_t compensate_sample(input logic [19:0] raw_p,
                                                   input logic [19:0] raw_t,
                                                   input logic [15:0] raw_h);
        reading_t    r;
        logic [31:0] rt, rh, t1, t2, t3, ta, td, tb, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, ps, w1, w2;
        logic [31:0] h1, h2, h3, h4, h5, h6, hv, hx, hy, hq;
        rt = {12'd0, raw_t};
        rh = {16'd0, raw_h};

        // temperature and fine temperature
        t1 = {16'd0, trim_temp[15:0]};
        t2 = {{16{trim_temp[31]}}, trim_temp[31:16]};
        t3 = {{16{trim_temp[47]}}, trim_temp[47:32]};
        ta = sra32(((rt >> 3) - (t1 << 1)) * t2, 11);
        td = (rt >> 4) - t1;
        tb = sra32(sra32(td * td, 12) * t3, 14);
        fine = ta + tb;
        r.fine_temp  = fine;
        r.temp_centi = sra32(fine * 32'd5 + 32'd128, 8);

        // pressure, 64-bit wrap
        p1 = {48'd0, trim_press_lo[15:0]};
        p2 = {{48{trim_press_lo[31]}}, trim_press_lo[31:16]};
        p3 = {{48{trim_press_lo[47]}}, trim_press_lo[47:32]};
        p4 = {{48{trim_press_lo[63]}}, trim_press_lo[63:48]};
        p5 = {{48{trim_press_hi[15]}}, trim_press_hi[15:0]};
        p6 = {{48{trim_press_hi[31]}}, trim_press_hi[31:16]};
        p7 = {{48{trim_press_hi[47]}}, trim_press_hi[47:32]};
        p8 = {{48{trim_press_hi[63]}}, trim_press_hi[63:48]};
        p9 = {{48{trim_p9[15]}}, trim_p9};
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
            r.pressure = '0;
            r.div_zero = 1'b1;
        end else begin
            p  = 64'd1048576 - {44'd0, raw_p};
            p  = div_trunc(((p << 31) - v2) * 64'd3125, v1);
            ps = sra64(p, 13);
            w1 = sra64(p9 * ps * ps, 25);
            w2 = sra64(p8 * p, 19);
            v2 = sra64(p + w1 + w2, 8) + (p7 << 4);
            r.pressure = v2[31:0];
            r.div_zero = 1'b0;
        end

        // humidity, 32-bit wrap, clamp then shift
        h1 = {24'd0, trim_hum[7:0]};
        h2 = {{16{trim_hum[23]}}, trim_hum[23:8]};
        h3 = {24'd0, trim_hum[31:24]};
        h4 = {{20{trim_hum[43]}}, trim_hum[43:32]};
        h5 = {{20{trim_hum[55]}}, trim_hum[55:44]};
        h6 = {{24{trim_hum[63]}}, trim_hum[63:56]};
        hv = fine - 32'd76800;
        hx = sra32((rh << 14) - (h4 << 20) - (h5 * hv) + 32'd16384, 15);
        hy = sra32(hv * h6, 10) * (sra32(hv * h3, 11) + 32'd32768);
        hy = sra32(hy, 10) + 32'd2097152;
        hy = sra32(hy * h2 + 32'd8192, 14);
        hv = hx * hy;
        hq = sra32(hv, 15);
        hv = hv - sra32(sra32(hq * hq, 7) * h1, 4);
        if (hv[31])
            hv = '0;
        else if (hv > 32'd419430400)
            hv = 32'd419430400;
        hv = hv >> 12;
        r.humidity = hv[16:0];
        return r;
    endfunction

    assign readings_pending = expected_readings.size();

    // Track trims, predict on sample transfers, compare on result transfers
    always @(posedge aclk) begin
        reading_t e;
        if (!aresetn) begin
            trim_temp     <= '0;
            trim_press_lo <= '0;
            trim_press_hi <= '0;
            trim_p9       <= '0;
            trim_hum      <= '0;
            expected_readings.delete();
            error_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TEMP_CALIB: trim_temp     <= cfg_wdata[47:0];
                    REG_PRESS_LOW:  trim_press_lo <= cfg_wdata;
                    REG_PRESS_HIGH: trim_press_hi <= cfg_wdata;
                    REG_PRESS_P9:   trim_p9       <= cfg_wdata[15:0];
                    REG_HUM_CALIB:  trim_hum      <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    error_count++;
                end else begin
                    e = expected_readings.pop_front();
                    if (m_temperature_centi !== e.temp_centi) begin
                        $error("temperature_centi: expected %0d, actual %0d",
                               $signed(e.temp_centi), m_temperature_centi);
                        error_count++;
                    end
                    if (m_fine_temperature !== e.fine_temp) begin
                        $error("fine_temperature: expected %0d, actual %0d",
                               $signed(e.fine_temp), m_fine_temperature);
                        error_count++;
                    end
                    if (m_pressure_q24_8 !== e.pressure) begin
                        $error("pressure_q24_8: expected %0d, actual %0d",
                               e.pressure, m_pressure_q24_8);
                        error_count++;
                    end
                    if (m_pressure_div_zero !== e.div_zero) begin
                        $error("pressure_div_zero: expected %0d, actual %0d",
                               e.div_zero, m_pressure_div_zero);
                        error_count++;
                    end
                    if (m_humidity_q22_10 !== e.humidity) begin
                        $error("humidity_q22_10: expected %0d, actual %0d",
                               e.humidity, m_humidity_q22_10);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_readings.push_back(compensate_sample(s_raw_pressure,
                                                              s_raw_temperature,
                                                              s_raw_humidity));
        end
    end

endmodule

// ===== tb/pth_sensor_compensation_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_sensor_compensation_unit_tb
// Drives raw samples and trim settings into the compensation pipeline under
// varying backpressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module pth_sensor_compensation_unit_tb;
    import pthc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int LATENCY      = PIPE_STAGES;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 320;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [63:0]          cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [19:0]          s_raw_pressure;
    logic [19:0]          s_raw_temperature;
    logic [15:0]          s_raw_humidity;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [31:0]   m_temperature_centi;
    logic signed [31:0]   m_fine_temperature;
    logic [31:0]          m_pressure_q24_8;
    logic                 m_pressure_div_zero;
    logic [16:0]          m_humidity_q22_10;
    int                   error_count;
    int                   readings_pending;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    bit                   long_hold;
    int                   cycle_count = 0;

    pth_sensor_compensation_unit dut (.*);
    pthc_checker u_checker (.*);

    always begin
        aclk = 1'b0; #6;
        aclk = 1'b1; #6;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold-off counted here
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_trims(input logic [63:0] t, input logic [63:0] pl,
                               input logic [63:0] ph, input logic [63:0] p9,
                               input logic [63:0] h);
        logic [63:0] vals[5];
        vals = '{t, pl, ph, p9, h};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= i[CFG_IDX_W-1:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        // out-of-range index must leave the trims alone
        cfg_addr  <= REG_UNUSED;
        cfg_wdata <= '1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Present one sample and hold it until the transfer
    task automatic send_sample(input logic [19:0] rp, input logic [19:0] rt,
                               input logic [15:0] rh);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid           <= 1'b1;
        s_raw_pressure    <= rp;
        s_raw_temperature <= rt;
        s_raw_humidity    <= rh;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (readings_pending != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic random_samples(input int n);
        logic [19:0] rt;
        for (int i = 0; i < n; i++) begin
            // mostly full range, some near room temperature
            rt = $urandom_range(3) == 0 ? 20'(500000 + $urandom_range(40000))
                                        : 20'($urandom);
            send_sample(20'($urandom), rt, 16'($urandom));
        end
    endtask

    // Walk the idling phases; the first run also holds off the receiver
    task automatic run_phases(input bit with_hold);
        int idle_set[4]  = '{0, 81, 0, 17};
        int stall_set[4] = '{0, 0, 81, 17};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            if (with_hold && ph == 0)
                long_hold = 1;
            random_samples(RANDOM_ITEMS / 4);
            if (ph == 1) begin
                // pause until everything is out
                s_valid <= 1'b0;
                while (readings_pending != 0) @(posedge aclk);
            end
        end
    endtask

    initial begin
        aresetn           <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_addr          <= '0;
        cfg_wdata         <= '0;
        s_valid           <= 1'b0;
        s_raw_pressure    <= '0;
        s_raw_temperature <= '0;
        s_raw_humidity    <= '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        long_hold         = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // trims at reset: zero divisor on every sample
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        drain();

        // typical datasheet-like trims, directed corners
        write_trims(64'h0000_FC18_6743_6B70,
                    {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477},
                    {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140},
                    64'hFFFF_FFFF_FFFF_1770,
                    {8'sd30, 12'sd50, 12'sd313, 8'd0, 16'sd362, 8'd75});
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        send_sample('0, '1, '0);
        send_sample('1, '0, '1);
        send_sample(20'h80000, 20'h80000, 16'h8000);
        send_sample(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
        send_sample(20'd415148, 20'd519888, 16'd30000);
        send_sample(20'd300000, 20'd600000, 16'd0);
        send_sample(20'd300000, 20'd450000, 16'hFFFF);
        send_sample(20'h55555, 20'hAAAAA, 16'h5555);
        send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
        drain();
        run_phases(1'b1);
        drain();

        // all trims at their maximum bit patterns
        write_trims('1, '1, '1, '1, '1);
        run_phases(1'b0);
        drain();

        // most negative signed trims, P1 zero to force the zero divisor
        write_trims(64'h8000_8000_0000, 64'h8000_8000_8000_0000,
                    64'h8000_8000_8000_8000, 64'h8000, 64'h8080_0800_0080_0000);
        send_sample('0, '1, '1);
        run_phases(1'b0);
        drain();

        // fully random trims, twice
        for (int k = 0; k < 2; k++) begin
            write_trims({$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom});
            run_phases(1'b0);
            drain();
        end

        if (error_count == 0 && readings_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== pth_sensor_compensation_unit.f =====
rtl/pthc_pkg.sv
rtl/pth_sensor_compensation_unit.sv
tb/pthc_checker.sv
tb/pth_sensor_compensation_unit_tb.sv
